/* rtl/core/rac_pkg.sv */
// ----------------------------------------------------------------------------
// rac_pkg
// Types and constants shared by the region average colour block.
// ----------------------------------------------------------------------------
package rac_pkg;

	localparam int COORD_W   = 11;
	localparam int SPAN_W    = 12;
	localparam int LEVEL_W   = 8;
	localparam int SUM_W     = 30;
	localparam int TALLY_W   = 23;
	localparam int COLOUR_W  = 24;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 12;
	localparam int QUOT_W    = 8;

	localparam logic [TALLY_W-1:0] TALLY_CAP = 23'd4194304;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd3;

	typedef struct packed {
		logic [SUM_W-1:0]   red_sum;
		logic [SUM_W-1:0]   green_sum;
		logic [SUM_W-1:0]   blue_sum;
		logic [TALLY_W-1:0] tally;
	} rac_job_t;

	typedef struct packed {
		logic     valid;
		rac_job_t job;
	} rac_head_t;

endpackage

/* rtl/core/rac_ifs.sv */
// ----------------------------------------------------------------------------
// rac_ifs
// Valid/ready channels of the region average colour block.
// ----------------------------------------------------------------------------
interface rac_pixel_if;
	import rac_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [LEVEL_W-1:0] blue_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] red_level;
	logic               frame_end;
	modport source (output valid, pixel_x, pixel_y, blue_level, green_level, red_level,
		frame_end, input ready);
	modport sink (input valid, pixel_x, pixel_y, blue_level, green_level, red_level,
		frame_end, output ready);
endinterface

interface rac_cfg_if;
	import rac_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface rac_result_if;
	import rac_pkg::*;
	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] average_colour;
	logic [TALLY_W-1:0]  counted_pixels;
	modport source (output valid, average_colour, counted_pixels, input ready);
	modport sink (input valid, average_colour, counted_pixels, output ready);
endinterface

/* rtl/core/rac_front.sv */
// ----------------------------------------------------------------------------
// rac_front
// Takes pixels, checks them against the region and accumulates the sums;
// a frame end pushes the finished sums into the job queue.
// ----------------------------------------------------------------------------
module rac_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	rac_pixel_if.sink         pixel,
	rac_cfg_if.sink           cfg,
	input  logic              queue_full,
	output logic              push,
	output rac_pkg::rac_job_t push_job
);
	import rac_pkg::*;

	localparam int LIM_W = COORD_W + 2;
	localparam logic [LIM_W-1:0] LIMIT_X = LIM_W'(MAX_WIDTH);
	localparam logic [LIM_W-1:0] LIMIT_Y = LIM_W'(MAX_HEIGHT);

	logic [COORD_W-1:0] left_q, top_q;
	logic [SPAN_W-1:0]  width_q, height_q;
	logic [SUM_W-1:0]   red_sum_q, green_sum_q, blue_sum_q;
	logic [TALLY_W-1:0] tally_q;

	logic               accept, hit_x, hit_y, take;
	logic [COORD_W-1:0] off_x, off_y;
	logic [SUM_W-1:0]   red_nxt, green_nxt, blue_nxt;
	logic [TALLY_W-1:0] tally_nxt;

	assign cfg.ready   = 1'b1;
	assign pixel.ready = !queue_full;
	assign accept      = pixel.valid && pixel.ready;

	assign off_x = pixel.pixel_x - left_q;
	assign off_y = pixel.pixel_y - top_q;
	assign hit_x = ({2'b00, pixel.pixel_x} < LIMIT_X) && (pixel.pixel_x >= left_q)
		&& ({1'b0, off_x} < width_q);
	assign hit_y = ({2'b00, pixel.pixel_y} < LIMIT_Y) && (pixel.pixel_y >= top_q)
		&& ({1'b0, off_y} < height_q);
	assign take  = hit_x && hit_y && (tally_q < TALLY_CAP);

	always_comb begin
		red_nxt   = red_sum_q;
		green_nxt = green_sum_q;
		blue_nxt  = blue_sum_q;
		tally_nxt = tally_q;
		if (take) begin
			red_nxt   = red_sum_q + SUM_W'(pixel.red_level);
			green_nxt = green_sum_q + SUM_W'(pixel.green_level);
			blue_nxt  = blue_sum_q + SUM_W'(pixel.blue_level);
			tally_nxt = tally_q + 1'b1;
		end
	end

	assign push               = accept && pixel.frame_end;
	assign push_job.red_sum   = red_nxt;
	assign push_job.green_sum = green_nxt;
	assign push_job.blue_sum  = blue_nxt;
	assign push_job.tally     = tally_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEFT:   left_q   <= cfg.data[COORD_W-1:0];
				REG_TOP:    top_q    <= cfg.data[COORD_W-1:0];
				REG_WIDTH:  width_q  <= cfg.data[SPAN_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sum_q   <= '0;
			green_sum_q <= '0;
			blue_sum_q  <= '0;
			tally_q     <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				red_sum_q   <= '0;
				green_sum_q <= '0;
				blue_sum_q  <= '0;
				tally_q     <= '0;
			end else begin
				red_sum_q   <= red_nxt;
				green_sum_q <= green_nxt;
				blue_sum_q  <= blue_nxt;
				tally_q     <= tally_nxt;
			end
		end
	end

endmodule

/* rtl/core/rac_queue.sv */
// ----------------------------------------------------------------------------
// rac_queue
// Two-entry queue of finished frame sums between front and back.
// ----------------------------------------------------------------------------
module rac_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rac_pkg::rac_job_t  push_job,
	output logic               full,
	input  logic               pop,
	output rac_pkg::rac_head_t head
);
	import rac_pkg::*;

	rac_job_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/rac_back.sv */
// ----------------------------------------------------------------------------
// rac_back
// Divides the three channel sums by the tally one quotient bit per cycle
// and holds the packed mean colour in the output register.
// ----------------------------------------------------------------------------
module rac_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rac_pkg::rac_head_t head,
	output logic               pop,
	rac_result_if.source       result
);
	import rac_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [2:0]         step_q;
	logic [SUM_W-1:0]   rem_r_q, rem_g_q, rem_b_q, dsr_q;
	logic [QUOT_W-1:0]  quo_r_q, quo_g_q, quo_b_q;
	logic [TALLY_W-1:0] tally_q;

	logic               res_valid_q;
	logic [COLOUR_W-1:0] res_colour_q;
	logic [TALLY_W-1:0] res_count_q;

	logic               ge_r, ge_g, ge_b, load_res;

	assign ge_r = (rem_r_q >= dsr_q);
	assign ge_g = (rem_g_q >= dsr_q);
	assign ge_b = (rem_b_q >= dsr_q);

	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign load_res = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	assign result.valid          = res_valid_q;
	assign result.average_colour = res_colour_q;
	assign result.counted_pixels = res_count_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_r_q <= head.job.red_sum;
				rem_g_q <= head.job.green_sum;
				rem_b_q <= head.job.blue_sum;
				dsr_q   <= SUM_W'(head.job.tally) << (QUOT_W - 1);
				tally_q <= head.job.tally;
			end
			ST_DIV: begin
				if (ge_r) rem_r_q <= rem_r_q - dsr_q;
				if (ge_g) rem_g_q <= rem_g_q - dsr_q;
				if (ge_b) rem_b_q <= rem_b_q - dsr_q;
				quo_r_q <= {quo_r_q[QUOT_W-2:0], ge_r};
				quo_g_q <= {quo_g_q[QUOT_W-2:0], ge_g};
				quo_b_q <= {quo_b_q[QUOT_W-2:0], ge_b};
				dsr_q   <= dsr_q >> 1;
			end
			default: ;
		endcase
		if (load_res) begin
			res_count_q <= tally_q;
			if (tally_q == '0) begin
				res_colour_q <= '0;
			end else begin
				res_colour_q <= {quo_r_q, quo_g_q, quo_b_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(QUOT_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/region_average_colour.sv */
// ----------------------------------------------------------------------------
// region_average_colour
// Mean red, green and blue of a rectangle of a raster pixel stream.
//
//   channel  role    payload
//   pixel    sink    pixel_x, pixel_y, blue_level, green_level, red_level, frame_end
//   cfg      sink    index, data (left, top, width, height)
//   result   source  average_colour, counted_pixels
//
// pixels are taken one per cycle; the front stalls only when both queue
// entries hold frames still waiting for the divider
// each frame end takes the back through load, 8 quotient bits, output
// cfg is always ready; reset clears the registers, sums, queue and output
// ----------------------------------------------------------------------------
module region_average_colour #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	rac_pixel_if.sink    pixel,
	rac_cfg_if.sink      cfg,
	rac_result_if.source result
);
	import rac_pkg::*;

	logic      push, queue_full, pop;
	rac_job_t  push_job;
	rac_head_t head;

	rac_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	rac_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.head     (head)
	);

	rac_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
